### src/stt_pkg.sv
package stt_pkg;

   typedef enum logic [1:0] {
      OP_ADD_ONESHOT  = 2'd0,
      OP_ADD_PERIODIC = 2'd1,
      OP_DELETE       = 2'd2,
      OP_TICK         = 2'd3
   } op_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   localparam int MAX_RESULTS = 16;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [7:0] fired_task;
      logic [7:0] fired_event;
      logic       fired_periodic;
      logic       last;
   } rsp_type;

   function automatic rsp_type status_rsp(input logic [1:0] code);
      rsp_type r;
      r                = '0;
      r.kind           = KIND_STATUS;
      r.status         = code;
      r.last           = 1'b1;
      return r;
   endfunction

endpackage

### src/stt_ram.sv
module stt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/stt_rsp_reg.sv
module stt_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  stt_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_fired_task,
   output logic [7:0]       rsp_fired_event,
   output logic             rsp_fired_periodic,
   output logic             rsp_last
);
   import stt_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign push_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = data_ff.kind;
   assign rsp_status         = data_ff.status;
   assign rsp_fired_task     = data_ff.fired_task;
   assign rsp_fired_event    = data_ff.fired_event;
   assign rsp_fired_periodic = data_ff.fired_periodic;
   assign rsp_last           = data_ff.last;

endmodule

### src/stt_engine.sv
module stt_engine #(
   parameter int TIMER_SLOTS   = 16,
   parameter int INTERVAL_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::op_type  req_operation,
   input  logic [7:0]       req_task_id,
   input  logic [7:0]       req_event_req,
   input  logic [31:0]      req_interval,
   output logic             push_valid,
   output stt_pkg::rsp_type push_data,
   input  logic             push_ready
);
   import stt_pkg::*;

   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int IB = INTERVAL_BITS;
   localparam int TW = 17 + 2 * IB;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_ALLOC,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [7:0]           task_ff, task_in;
   logic [7:0]           event_ff, event_in;
   logic [IB-1:0]        ivl_ff, ivl_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [IW-1:0]        tail_ff, tail_in;
   logic                 empty_ff, empty_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        prev_ff, prev_in;
   logic                 prev_none_ff, prev_none_in;
   rsp_type              pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          tm_wr_en;
   logic [IW-1:0] tm_wr_addr;
   logic [TW-1:0] tm_wr_data;
   logic [TW-1:0] tm_rd_data;
   logic          lk_wr_en;
   logic [IW-1:0] lk_wr_addr;
   logic [IW-1:0] lk_wr_data;
   logic [IW-1:0] nxt;

   logic [7:0]    rd_task;
   logic [7:0]    rd_event;
   logic          rd_per;
   logic [IB-1:0] rd_ivl;
   logic [IB-1:0] rd_elapsed;
   logic [IB-1:0] elapsed_inc;
   logic [IB-1:0] new_elapsed;
   logic          at_end;
   logic          hit_valid;
   logic          match;
   logic          fire;
   logic          capture;
   logic          do_unlink;
   logic          do_advance;
   logic          walk_done;
   logic [IW-1:0] free_idx;
   logic          table_full;

   stt_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(TW)) u_timer_ram (
      .clock   (clock),
      .wr_en   (tm_wr_en),
      .wr_addr (tm_wr_addr),
      .wr_data (tm_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tm_rd_data)
   );

   stt_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(IW)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_wr_en),
      .wr_addr (lk_wr_addr),
      .wr_data (lk_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (nxt)
   );

   assign {rd_task, rd_event, rd_per, rd_ivl, rd_elapsed} = tm_rd_data;

   assign at_end      = (cur_ff == tail_ff);
   assign hit_valid   = valid_ff[cur_ff];
   assign match       = hit_valid && (rd_task == task_ff) && (rd_event == event_ff);
   assign elapsed_inc = rd_elapsed + 1'b1;
   assign fire        = hit_valid && (elapsed_inc >= rd_ivl);
   assign capture     = fire && (cnt_ff < CNT_BITS'(MAX_RESULTS));
   assign new_elapsed = (fire && rd_per) ? '0 : elapsed_inc;

   always_comb begin
      free_idx   = '0;
      table_full = 1'b1;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = IW'(i);
            table_full = 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      task_in       = task_ff;
      event_in      = event_ff;
      ivl_in        = ivl_ff;
      valid_in      = valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_none_in  = prev_none_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cnt_in        = cnt_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      tm_wr_en      = 1'b0;
      tm_wr_addr    = cur_ff;
      tm_wr_data    = {rd_task, rd_event, rd_per, rd_ivl, new_elapsed};
      lk_wr_en      = 1'b0;
      lk_wr_addr    = prev_ff;
      lk_wr_data    = nxt;
      push_valid    = 1'b0;
      push_data     = pend_ff;
      do_unlink     = 1'b0;
      do_advance    = 1'b0;
      walk_done     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_operation;
               task_in       = req_task_id;
               event_in      = req_event_req;
               ivl_in        = IB'(req_interval);
               cur_in        = head_ff;
               prev_none_in  = 1'b1;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               if (empty_ff) begin
                  unique case (req_operation) inside
                     OP_ADD_ONESHOT, OP_ADD_PERIODIC: state_in = ST_ALLOC;
                     OP_DELETE: begin
                        pend_in       = status_rsp(STATUS_NOT_FOUND);
                        pend_valid_in = 1'b1;
                        state_in      = ST_FLUSH;
                     end
                     OP_TICK: state_in = ST_IDLE;
                  endcase
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            unique case (op_ff) inside
               OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
                  if (match) begin
                     pend_in       = status_rsp(STATUS_OK);
                     pend_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else if (at_end) begin
                     state_in = ST_ALLOC;
                  end else begin
                     do_advance = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (match) begin
                     do_unlink     = 1'b1;
                     pend_in       = status_rsp(STATUS_OK);
                     pend_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else if (at_end) begin
                     pend_in       = status_rsp(STATUS_NOT_FOUND);
                     pend_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else begin
                     do_advance = 1'b1;
                  end
               end
               OP_TICK: begin
                  if (!(capture && pend_valid_ff && !push_ready)) begin
                     tm_wr_en = hit_valid;
                     if (capture) begin
                        if (pend_valid_ff) begin
                           push_valid     = 1'b1;
                           push_data.last = 1'b0;
                        end
                        pend_in.kind           = KIND_EXPIRY;
                        pend_in.status         = STATUS_OK;
                        pend_in.fired_task     = rd_task;
                        pend_in.fired_event    = rd_event;
                        pend_in.fired_periodic = rd_per;
                        pend_in.last           = 1'b1;
                        pend_valid_in          = 1'b1;
                        cnt_in                 = cnt_ff + 1'b1;
                     end
                     if (fire && !rd_per) begin
                        do_unlink = 1'b1;
                        walk_done = 1'b1;
                     end else if (at_end) begin
                        walk_done = 1'b1;
                     end else begin
                        do_advance = 1'b1;
                     end
                     if (walk_done) begin
                        state_in = pend_valid_in ? ST_FLUSH : ST_IDLE;
                     end
                  end
               end
            endcase
         end
         ST_ALLOC: begin
            pend_valid_in = 1'b1;
            state_in      = ST_FLUSH;
            if (table_full) begin
               pend_in = status_rsp(STATUS_FULL);
            end else begin
               pend_in    = status_rsp(STATUS_OK);
               tm_wr_en   = 1'b1;
               tm_wr_addr = free_idx;
               tm_wr_data = {task_ff, event_ff, (op_ff == OP_ADD_PERIODIC), ivl_ff, {IB{1'b0}}};
               valid_in[free_idx] = 1'b1;
               if (empty_ff) begin
                  head_in  = free_idx;
                  empty_in = 1'b0;
               end else begin
                  lk_wr_en   = 1'b1;
                  lk_wr_addr = tail_ff;
                  lk_wr_data = free_idx;
               end
               tail_in = free_idx;
            end
         end
         ST_FLUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (do_advance) begin
         prev_in      = cur_ff;
         prev_none_in = 1'b0;
         cur_in       = nxt;
         rd_en        = 1'b1;
         rd_addr      = nxt;
      end

      if (do_unlink) begin
         valid_in[cur_ff] = 1'b0;
         if (prev_none_ff) begin
            if (at_end) begin
               empty_in = 1'b1;
            end else begin
               head_in = nxt;
            end
         end else begin
            lk_wr_en   = 1'b1;
            lk_wr_addr = prev_ff;
            lk_wr_data = nxt;
         end
         if (at_end) begin
            tail_in = prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      task_ff      <= task_in;
      event_ff     <= event_in;
      ivl_ff       <= ivl_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_none_ff <= prev_none_in;
      pend_ff      <= pend_in;
      cnt_ff       <= cnt_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         empty_ff      <= 1'b1;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         empty_ff      <= empty_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

### src/software_timer_table_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  operation, task_id, event_req, interval
// rsp       out        rsp_valid / rsp_ready  kind, status, fired_task, fired_event,
//                                             fired_periodic, last
//
// One item at a time. The timer list is walked one slot per cycle, unless a stalled
// rsp channel holds it, from the slot memories (one read port, registered read).
// Reset empties the list and clears the slot valid bits; the memories are not cleared.
// A stalled rsp channel holds the walk only when a second expiry needs the output.
module software_timer_table_top #(
   parameter int TIMER_SLOTS   = 16,
   parameter int INTERVAL_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_event_req,
   input  logic [31:0] req_interval,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_fired_task,
   output logic [7:0]  rsp_fired_event,
   output logic        rsp_fired_periodic,
   output logic        rsp_last
);
   import stt_pkg::*;

   logic    push_valid;
   logic    push_ready;
   rsp_type push_data;

   stt_engine #(
      .TIMER_SLOTS   (TIMER_SLOTS),
      .INTERVAL_BITS (INTERVAL_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (op_type'(req_operation)),
      .req_task_id   (req_task_id),
      .req_event_req (req_event_req),
      .req_interval  (req_interval),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .push_ready    (push_ready)
   );

   stt_rsp_reg u_rsp_reg (
      .clock              (clock),
      .reset              (reset),
      .push_valid         (push_valid),
      .push_data          (push_data),
      .push_ready         (push_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_fired_task     (rsp_fired_task),
      .rsp_fired_event    (rsp_fired_event),
      .rsp_fired_periodic (rsp_fired_periodic),
      .rsp_last           (rsp_last)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import stt_pkg::*;

   localparam int SLOTS       = 16;
   localparam int NIL         = SLOTS;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      op_type      op;
      logic [7:0]  tsk;
      logic [7:0]  evt;
      logic [31:0] ivl;
      bit          drain_first;
   } timer_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_TICK;
   logic [7:0]  req_task_id = '0;
   logic [7:0]  req_event_req = '0;
   logic [31:0] req_interval = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_fired_task;
   logic [7:0]  rsp_fired_event;
   logic        rsp_fired_periodic;
   logic        rsp_last;

   software_timer_table_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_task_id        (req_task_id),
      .req_event_req      (req_event_req),
      .req_interval       (req_interval),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_fired_task     (rsp_fired_task),
      .rsp_fired_event    (rsp_fired_event),
      .rsp_fired_periodic (rsp_fired_periodic),
      .rsp_last           (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // timer table shadow
   bit          timer_live [SLOTS];
   logic [7:0]  timer_task [SLOTS];
   logic [7:0]  timer_evt [SLOTS];
   bit          timer_periodic [SLOTS];
   logic [31:0] timer_ivl [SLOTS];
   logic [31:0] timer_count [SLOTS];
   int          link_next [SLOTS];
   int          list_head = NIL;
   int          list_tail = NIL;

   timer_cmd_type pending_cmds[$];
   rsp_type     expected_rsp[$];
   int          issued_cnt = 0;
   int          seen_cnt = 0;
   int          bad_cnt = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_armed = 1'b0;
   int          hold_count = 0;
   wire         hold_active = hold_armed && (hold_count < HOLD_CYCLES);

   function automatic rsp_type status_result(input logic [1:0] code);
      rsp_type r;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = code;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic int find_timer(input logic [7:0] tsk, input logic [7:0] evt,
                                     output int prev);
      int cur;
      int p;
      cur  = list_head;
      p    = NIL;
      prev = NIL;
      for (int s = 0; s < SLOTS && cur < SLOTS; s++) begin
         if (timer_live[cur] && timer_task[cur] == tsk && timer_evt[cur] == evt) begin
            prev = p;
            return cur;
         end
         if (cur == list_tail) break;
         p   = cur;
         cur = link_next[cur];
      end
      return NIL;
   endfunction

   function automatic void unlink_timer(input int prev, input int cur);
      int nxt;
      nxt = (cur == list_tail) ? NIL : link_next[cur];
      if (prev >= SLOTS) list_head = nxt;
      else link_next[prev] = (nxt < SLOTS) ? nxt : 0;
      if (cur == list_tail) list_tail = prev;
      timer_live[cur] = 1'b0;
   endfunction

   // updates the shadow table and queues the results of one request
   function automatic int predict_timer_op(input op_type op, input logic [7:0] tsk,
                                           input logic [7:0] evt, input logic [31:0] ivl);
      int      hit;
      int      prev;
      int      free_slot;
      int      cur;
      int      nxt;
      int      n;
      bit      at_end;
      rsp_type fired [MAX_RESULTS];
      n = 0;
      case (op) inside
         OP_ADD_ONESHOT, OP_ADD_PERIODIC: begin
            hit = find_timer(tsk, evt, prev);
            if (hit < SLOTS) begin
               expected_rsp.push_back(status_result(STATUS_OK));
               return 1;
            end
            free_slot = NIL;
            for (int i = 0; i < SLOTS; i++) begin
               if (!timer_live[i]) begin
                  free_slot = i;
                  break;
               end
            end
            if (free_slot >= SLOTS) begin
               expected_rsp.push_back(status_result(STATUS_FULL));
               return 1;
            end
            timer_live[free_slot]     = 1'b1;
            timer_task[free_slot]     = tsk;
            timer_evt[free_slot]      = evt;
            timer_periodic[free_slot] = (op == OP_ADD_PERIODIC);
            timer_ivl[free_slot]      = ivl;
            timer_count[free_slot]    = '0;
            link_next[free_slot]      = 0;
            if (list_head >= SLOTS || list_tail >= SLOTS) list_head = free_slot;
            else link_next[list_tail] = free_slot;
            list_tail = free_slot;
            expected_rsp.push_back(status_result(STATUS_OK));
            return 1;
         end
         OP_DELETE: begin
            hit = find_timer(tsk, evt, prev);
            if (hit >= SLOTS) begin
               expected_rsp.push_back(status_result(STATUS_NOT_FOUND));
               return 1;
            end
            unlink_timer(prev, hit);
            expected_rsp.push_back(status_result(STATUS_OK));
            return 1;
         end
         default: begin
            cur  = list_head;
            prev = NIL;
            for (int s = 0; s < SLOTS && cur < SLOTS; s++) begin
               at_end = (cur == list_tail);
               nxt    = link_next[cur];
               if (timer_live[cur]) begin
                  timer_count[cur] = timer_count[cur] + 1;
                  if (timer_count[cur] >= timer_ivl[cur]) begin
                     if (n < MAX_RESULTS) begin
                        fired[n]                = '0;
                        fired[n].kind           = KIND_EXPIRY;
                        fired[n].status         = STATUS_OK;
                        fired[n].fired_task     = timer_task[cur];
                        fired[n].fired_event    = timer_evt[cur];
                        fired[n].fired_periodic = timer_periodic[cur];
                        n++;
                     end
                     if (!timer_periodic[cur]) begin
                        unlink_timer(prev, cur);
                        break;
                     end
                     timer_count[cur] = '0;
                  end
               end
               if (at_end) break;
               prev = cur;
               cur  = nxt;
            end
            for (int k = 0; k < n; k++) begin
               fired[k].last = (k == n - 1);
               expected_rsp.push_back(fired[k]);
            end
            return n;
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : req_driver
      int            n;
      timer_cmd_type cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         n = 0;
         if (req_valid && req_ready)
            n = predict_timer_op(op_type'(req_operation), req_task_id, req_event_req,
                                 req_interval);
         issued_cnt <= issued_cnt + n;
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() > 0 &&
                !(pending_cmds[0].drain_first && issued_cnt + n != seen_cnt) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               cmd = pending_cmds.pop_front();
               req_valid     <= 1'b1;
               req_operation <= cmd.op;
               req_task_id   <= cmd.tsk;
               req_event_req <= cmd.evt;
               req_interval  <= cmd.ivl;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : hold_counter
      if (reset) hold_count <= 0;
      else if (hold_active) hold_count <= hold_count + 1;
   end

   always @(posedge clock) begin : rsp_stall
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind           = rsp_kind;
         got.status         = rsp_status;
         got.fired_task     = rsp_fired_task;
         got.fired_event    = rsp_fired_event;
         got.fired_periodic = rsp_fired_periodic;
         got.last           = rsp_last;
         if (seen_cnt == issued_cnt) begin
            if (bad_cnt < 10)
               $display("%0t: unexpected transfer: kind=%0d status=%0d task=%h event=%h",
                        $realtime, got.kind, got.status, got.fired_task, got.fired_event);
            bad_cnt = bad_cnt + 1;
         end else begin
            want = expected_rsp.pop_front();
            seen_cnt <= seen_cnt + 1;
            if (got !== want) begin
               if (bad_cnt < 10)
                  $display({"%0t: mismatch exp kind=%0d status=%0d task=%h event=%h ",
                            "per=%0d last=%0d / got kind=%0d status=%0d task=%h event=%h ",
                            "per=%0d last=%0d"},
                           $realtime, want.kind, want.status, want.fired_task,
                           want.fired_event, want.fired_periodic, want.last,
                           got.kind, got.status, got.fired_task, got.fired_event,
                           got.fired_periodic, got.last);
               bad_cnt = bad_cnt + 1;
            end
         end
      end
   end

   function automatic logic [7:0] pool_id(input int i);
      case (i)
         0:       return 8'h00;
         1:       return 8'h5A;
         2:       return 8'hA5;
         default: return 8'hFF;
      endcase
   endfunction

   task automatic push_cmd(input op_type op, input logic [7:0] tsk, input logic [7:0] evt,
                           input logic [31:0] ivl, input bit drain_first);
      timer_cmd_type cmd;
      cmd.op          = op;
      cmd.tsk         = tsk;
      cmd.evt         = evt;
      cmd.ivl         = ivl;
      cmd.drain_first = drain_first;
      pending_cmds.push_back(cmd);
   endtask

   task automatic push_random(input int count);
      int          r;
      op_type      op;
      logic [7:0]  tsk;
      logic [7:0]  evt;
      logic [31:0] ivl;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) op = OP_TICK;
         else if (r < 55) op = OP_ADD_ONESHOT;
         else if (r < 72) op = OP_ADD_PERIODIC;
         else op = OP_DELETE;
         if ($urandom_range(0, 99) < 80) begin
            tsk = pool_id($urandom_range(0, 3));
            evt = pool_id($urandom_range(0, 3));
         end else begin
            tsk = 8'($urandom_range(0, 255));
            evt = 8'($urandom_range(0, 255));
         end
         r = $urandom_range(0, 99);
         if (r < 65) ivl = $urandom_range(0, 4);
         else if (r < 90) ivl = $urandom_range(5, 60);
         else ivl = $urandom;
         push_cmd(op, tsk, evt, ivl, (i == 0) || ($urandom_range(0, 99) < 3));
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || issued_cnt != seen_cnt)
         @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed: empty table, one-shot zero interval, periodic, fill, full, big tick
      push_cmd(OP_TICK, 8'h00, 8'h00, 32'd0, 1'b0);
      push_cmd(OP_DELETE, 8'h5A, 8'hFF, 32'd0, 1'b0);
      push_cmd(OP_ADD_ONESHOT, 8'h00, 8'h00, 32'd0, 1'b0);
      push_cmd(OP_TICK, 8'h00, 8'h00, 32'd0, 1'b0);
      push_cmd(OP_ADD_PERIODIC, 8'h5A, 8'hA5, 32'd1, 1'b0);
      push_cmd(OP_ADD_ONESHOT, 8'hA5, 8'h5A, 32'd2, 1'b0);
      push_cmd(OP_TICK, 8'h00, 8'h00, 32'd0, 1'b0);
      push_cmd(OP_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      for (int t = 0; t < 4; t++) begin
         for (int e = 0; e < 4; e++) begin
            if (t == 3 && e == 3)
               push_cmd(OP_ADD_ONESHOT, pool_id(t), pool_id(e), 32'hFFFF_FFFF, 1'b0);
            else
               push_cmd(OP_ADD_PERIODIC, pool_id(t), pool_id(e), 32'd0, 1'b0);
         end
      end
      push_cmd(OP_ADD_ONESHOT, 8'h42, 8'h24, 32'd7, 1'b0);
      push_cmd(OP_TICK, 8'h00, 8'h00, 32'd0, 1'b0);
      wait_drained();

      // long receiver hold-off while requests keep coming
      hold_armed = 1'b1;
      push_random(30);
      wait_drained();
      while (hold_active) @(negedge clock);

      push_random(31);
      wait_drained();

      send_idle_pct = 88;
      push_random(31);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 88;
      push_random(31);
      wait_drained();

      send_idle_pct  = 27;
      recv_stall_pct = 27;
      push_random(31);
      wait_drained();

      repeat (64) @(negedge clock);
      if (bad_cnt == 0 && issued_cnt == seen_cnt) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
